// File: rtl/cau_pkg.sv
// shared constants, opcode and status codes, and the pipeline control bundle
// for the complex arithmetic unit; no dependencies
package cau_pkg;

    localparam int IO_BITS       = 32;
    localparam int OP_BITS       = 3;
    localparam int ST_BITS       = 2;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_COPY = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_SQRT = 3'd5
    } op_t;

    typedef enum logic [ST_BITS-1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
        logic dz;
        logic sat;
    } ctl_t;

endpackage

// File: rtl/cau_div_cell.sv
// one restoring division step for both result lanes, one quotient bit a lane
// depends on cau_pkg for the default word width
module cau_div_cell #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [2*WORD_BITS-1:0]   d_in,
    input  logic [2*WORD_BITS-1:0]   rem_re_in,
    input  logic [2*WORD_BITS-1:0]   rem_im_in,
    input  logic [WORD_BITS-1:0]     xl_re_in,
    input  logic [WORD_BITS-1:0]     xl_im_in,
    input  logic [WORD_BITS-1:0]     q_re_in,
    input  logic [WORD_BITS-1:0]     q_im_in,
    output logic [2*WORD_BITS-1:0]   d_out,
    output logic [2*WORD_BITS-1:0]   rem_re_out,
    output logic [2*WORD_BITS-1:0]   rem_im_out,
    output logic [WORD_BITS-1:0]     xl_re_out,
    output logic [WORD_BITS-1:0]     xl_im_out,
    output logic [WORD_BITS-1:0]     q_re_out,
    output logic [WORD_BITS-1:0]     q_im_out
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;

    logic [PW:0]   try_re;
    logic [PW:0]   try_im;
    logic [PW:0]   dif_re;
    logic [PW:0]   dif_im;
    logic          ge_re;
    logic          ge_im;
    logic [PW-1:0] rem_re_next;
    logic [PW-1:0] rem_im_next;

    logic [PW-1:0] d_reg;
    logic [PW-1:0] rem_re_reg;
    logic [PW-1:0] rem_im_reg;
    logic [W-1:0]  xl_re_reg;
    logic [W-1:0]  xl_im_reg;
    logic [W-1:0]  q_re_reg;
    logic [W-1:0]  q_im_reg;

    always_comb
    begin
        try_re      = {rem_re_in, xl_re_in[W-1]};
        try_im      = {rem_im_in, xl_im_in[W-1]};
        dif_re      = try_re - {1'b0, d_in};
        dif_im      = try_im - {1'b0, d_in};
        ge_re       = try_re >= {1'b0, d_in};
        ge_im       = try_im >= {1'b0, d_in};
        rem_re_next = ge_re ? dif_re[PW-1:0] : try_re[PW-1:0];
        rem_im_next = ge_im ? dif_im[PW-1:0] : try_im[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg      <= d_in;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            xl_re_reg  <= {xl_re_in[W-2:0], 1'b0};
            xl_im_reg  <= {xl_im_in[W-2:0], 1'b0};
            q_re_reg   <= {q_re_in[W-2:0], ge_re};
            q_im_reg   <= {q_im_in[W-2:0], ge_im};
        end
    end

    assign d_out      = d_reg;
    assign rem_re_out = rem_re_reg;
    assign rem_im_out = rem_im_reg;
    assign xl_re_out  = xl_re_reg;
    assign xl_im_out  = xl_im_reg;
    assign q_re_out   = q_re_reg;
    assign q_im_out   = q_im_reg;

endmodule

// File: rtl/cau_sqrt_cell.sv
// one restoring square root step, two radicand bits in and one root bit out
// depends on cau_pkg for the default width
module cau_sqrt_cell #(
    parameter int ROOT_BITS = cau_pkg::WORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [ROOT_BITS:0]     rem_in,
    input  logic [ROOT_BITS-1:0]   root_in,
    input  logic [2*ROOT_BITS-1:0] xs_in,
    output logic [ROOT_BITS:0]     rem_out,
    output logic [ROOT_BITS-1:0]   root_out,
    output logic [2*ROOT_BITS-1:0] xs_out
);

    localparam int NB = ROOT_BITS;

    logic [NB+1:0]   rem2;
    logic [NB+1:0]   trial;
    logic [NB+1:0]   dif;
    logic            ge;
    logic [NB:0]     rem_next;

    logic [NB:0]     rem_reg;
    logic [NB-1:0]   root_reg;
    logic [2*NB-1:0] xs_reg;

    always_comb
    begin
        rem2     = {rem_in[NB-1:0], xs_in[2*NB-1 -: 2]};
        trial    = {root_in, 2'b01};
        dif      = rem2 - trial;
        ge       = rem2 >= trial;
        rem_next = ge ? dif[NB:0] : rem2[NB:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= {root_in[NB-2:0], ge};
            xs_reg   <= {xs_in[2*NB-3:0], 2'b00};
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign xs_out   = xs_reg;

endmodule

// File: rtl/complex_arithmetic_unit.sv
// complex arithmetic unit: copy, add, subtract, multiply, divide, square root
// depends on cau_pkg, cau_div_cell and cau_sqrt_cell
// Fully pipelined: one beat is accepted every cycle while in_stall is low, and results
// leave in order; the default format is Q15.16 in 32 bits. The depth is set by the
// row of WORD_BITS divide cells (with root cells beside them that take the modulus
// root) and the row of root cells that follows, which takes the roots of the half sums.
// Multiplies truncate by floor, quotients toward zero, roots round down; a part
// that overflows the word clamps and reports status 2, a zero divisor gives a
// zero result with status 1. The whole pipeline holds while a result beat is
// waiting with out_stall high; with no result waiting, out_stall is ignored.
module complex_arithmetic_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [cau_pkg::OP_BITS-1:0]           op,
    input  logic signed [cau_pkg::IO_BITS-1:0]    a_re,
    input  logic signed [cau_pkg::IO_BITS-1:0]    a_im,
    input  logic signed [cau_pkg::IO_BITS-1:0]    b_re,
    input  logic signed [cau_pkg::IO_BITS-1:0]    b_im,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [cau_pkg::IO_BITS-1:0]    res_re,
    output logic signed [cau_pkg::IO_BITS-1:0]    res_im,
    output logic [cau_pkg::ST_BITS-1:0]           status
);

    localparam int IO  = cau_pkg::IO_BITS;
    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 1;
    localparam int XW  = PW + F;
    localparam int RW  = W + F;
    localparam int CW  = (RW > PW) ? RW : PW;
    localparam int NB2 = (W + F + 1) / 2;
    localparam int X2W = 2 * NB2;
    localparam int TW  = W + F + 1;
    localparam int MX  = ((NB2 > W) ? NB2 : W) + 1;

    localparam logic [IO-1:0] SAT_POS = IO'({(W-1){1'b1}});
    localparam logic [IO-1:0] SAT_NEG = ~SAT_POS;

    function automatic logic [W:0] sat_sgn(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] smax;
        logic signed [SW-1:0] smin;
        smax = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
        smin = ~smax;
        if (v > smax)
            sat_sgn = {1'b1, smax[W-1:0]};
        else if (v < smin)
            sat_sgn = {1'b1, smin[W-1:0]};
        else
            sat_sgn = {1'b0, v[W-1:0]};
    endfunction

    function automatic logic [W:0] pack_mag(input logic neg, input logic ovf,
                                            input logic [MX-1:0] mag);
        logic [MX-1:0] lim;
        logic          sat;
        logic [W-1:0]  lo;
        lim = neg ? (MX'(1) << (W-1)) : ((MX'(1) << (W-1)) - MX'(1));
        sat = ovf || (mag > lim);
        lo  = sat ? lim[W-1:0] : mag[W-1:0];
        pack_mag = {sat, neg ? (W'(0) - lo) : lo};
    endfunction

    logic adv;

    // input stage
    cau_pkg::ctl_t        s1_ctl_reg;
    cau_pkg::ctl_t        s1_ctl_next;
    logic signed [W-1:0]  s1_ar_reg;
    logic signed [W-1:0]  s1_ai_reg;
    logic signed [W-1:0]  s1_br_reg;
    logic signed [W-1:0]  s1_bi_reg;

    // products
    cau_pkg::ctl_t        s2_ctl_reg;
    cau_pkg::ctl_t        s2_ctl_next;
    logic                 is_sqrt;
    logic signed [W-1:0]  m0b;
    logic signed [W-1:0]  m1b;
    logic signed [W:0]    add_re;
    logic signed [W:0]    add_im;
    logic signed [W:0]    sub_re;
    logic signed [W:0]    sub_im;
    logic signed [W:0]    smp_re;
    logic signed [W:0]    smp_im;
    logic [W:0]           pk_re2;
    logic [W:0]           pk_im2;
    logic [2*W-1:0]       s2_side_next;
    logic [2*W-1:0]       s2_side_reg;
    logic signed [PW-1:0] s2_p0_reg;
    logic signed [PW-1:0] s2_p1_reg;
    logic signed [PW-1:0] s2_p2_reg;
    logic signed [PW-1:0] s2_p3_reg;
    logic signed [PW-1:0] s2_q0_reg;
    logic signed [PW-1:0] s2_q1_reg;

    // sums
    cau_pkg::ctl_t        s3_ctl_reg;
    logic [2*W-1:0]       s3_side_reg;
    logic signed [SW-1:0] s3_sr_next;
    logic signed [SW-1:0] s3_si_next;
    logic signed [SW-1:0] s3_sr_reg;
    logic signed [SW-1:0] s3_si_reg;
    logic [PW-1:0]        s3_d_reg;

    // rounding of products, magnitudes for the cell rows
    cau_pkg::ctl_t        s4_ctl_reg;
    cau_pkg::ctl_t        s4_ctl_next;
    logic [2*W-1:0]       s4_side_next;
    logic [2*W-1:0]       s4_side_reg;
    logic signed [SW-1:0] shr_re;
    logic signed [SW-1:0] shr_im;
    logic [W:0]           pk_re4;
    logic [W:0]           pk_im4;
    logic [SW-1:0]        abs_re;
    logic [SW-1:0]        abs_im;
    logic [PW-1:0]        s4_mr_reg;
    logic [PW-1:0]        s4_mi_reg;
    logic [PW-1:0]        s4_d_reg;

    // division setup
    cau_pkg::ctl_t        s5_ctl_next;
    logic [XW-1:0]        x_re;
    logic [XW-1:0]        x_im;
    logic [CW-1:0]        r0_re;
    logic [CW-1:0]        r0_im;
    logic [CW-1:0]        d_ext;
    logic                 ovf_re5;
    logic                 ovf_im5;
    logic [PW-1:0]        s5_rem_re_reg;
    logic [PW-1:0]        s5_rem_im_reg;
    logic [W-1:0]         s5_xl_re_reg;
    logic [W-1:0]         s5_xl_im_reg;
    logic [PW-1:0]        s5_d_reg;
    logic [PW-1:0]        s5_xs_reg;

    // first cell row: division and modulus root
    cau_pkg::ctl_t        ch1_ctl_reg [0:W];
    logic [2*W-1:0]       ch1_side_reg [0:W];
    logic [PW-1:0]        dv_d [0:W];
    logic [PW-1:0]        dv_rem_re [0:W];
    logic [PW-1:0]        dv_rem_im [0:W];
    logic [W-1:0]         dv_xl_re [0:W];
    logic [W-1:0]         dv_xl_im [0:W];
    logic [W-1:0]         dv_q_re [0:W];
    logic [W-1:0]         dv_q_im [0:W];
    logic [W:0]           sq_rem [0:W];
    logic [W-1:0]         sq_root [0:W];
    logic [PW-1:0]        sq_xs [0:W];

    // between the rows
    cau_pkg::ctl_t        t_ctl_next;
    logic [2*W-1:0]       t_side_next;
    logic signed [W-1:0]  t_ar;
    logic [W:0]           v_p;
    logic [W:0]           v_m;
    logic [TW-1:0]        tw_p;
    logic [TW-1:0]        tw_m;
    logic [W:0]           pk_re_t;
    logic [W:0]           pk_im_t;
    logic [X2W-1:0]       t_xs_re_reg;
    logic [X2W-1:0]       t_xs_im_reg;

    // second cell row: roots of the half sums
    cau_pkg::ctl_t        ch2_ctl_reg [0:NB2];
    logic [2*W-1:0]       ch2_side_reg [0:NB2];
    logic [NB2:0]         rr_rem [0:NB2];
    logic [NB2-1:0]       rr_root [0:NB2];
    logic [X2W-1:0]       rr_xs [0:NB2];
    logic [NB2:0]         ri_rem [0:NB2];
    logic [NB2-1:0]       ri_root [0:NB2];
    logic [X2W-1:0]       ri_xs [0:NB2];

    // output
    cau_pkg::ctl_t        oc;
    logic [W:0]           pk_re_o;
    logic [W:0]           pk_im_o;
    logic signed [W-1:0]  o_re_next;
    logic signed [W-1:0]  o_im_next;
    logic                 o_sat;
    logic [cau_pkg::ST_BITS-1:0] o_st_next;
    logic                 out_valid_reg;
    logic signed [IO-1:0] res_re_reg;
    logic signed [IO-1:0] res_im_reg;
    logic [cau_pkg::ST_BITS-1:0] status_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // stage 1
    always_comb
    begin
        s1_ctl_next        = '0;
        s1_ctl_next.valid  = in_valid;
        s1_ctl_next.op     = cau_pkg::op_t'(op);
        s1_ctl_next.neg_im = a_im[W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_ctl_reg <= '0;
        else if (adv)
            s1_ctl_reg <= s1_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ar_reg <= a_re[W-1:0];
            s1_ai_reg <= a_im[W-1:0];
            s1_br_reg <= b_re[W-1:0];
            s1_bi_reg <= b_im[W-1:0];
        end
    end

    // stage 2
    always_comb
    begin
        is_sqrt = s1_ctl_reg.op == cau_pkg::OP_SQRT;
        m0b     = is_sqrt ? s1_ar_reg : s1_br_reg;
        m1b     = is_sqrt ? s1_ai_reg : s1_bi_reg;
        add_re  = {s1_ar_reg[W-1], s1_ar_reg} + {s1_br_reg[W-1], s1_br_reg};
        add_im  = {s1_ai_reg[W-1], s1_ai_reg} + {s1_bi_reg[W-1], s1_bi_reg};
        sub_re  = {s1_ar_reg[W-1], s1_ar_reg} - {s1_br_reg[W-1], s1_br_reg};
        sub_im  = {s1_ai_reg[W-1], s1_ai_reg} - {s1_bi_reg[W-1], s1_bi_reg};
        case (s1_ctl_reg.op)
            cau_pkg::OP_COPY:
            begin
                smp_re = {s1_ar_reg[W-1], s1_ar_reg};
                smp_im = {s1_ai_reg[W-1], s1_ai_reg};
            end
            cau_pkg::OP_ADD:
            begin
                smp_re = add_re;
                smp_im = add_im;
            end
            cau_pkg::OP_SUB:
            begin
                smp_re = sub_re;
                smp_im = sub_im;
            end
            default:
            begin
                smp_re = '0;
                smp_im = '0;
            end
        endcase
        pk_re2          = sat_sgn(SW'(smp_re));
        pk_im2          = sat_sgn(SW'(smp_im));
        s2_ctl_next     = s1_ctl_reg;
        s2_ctl_next.sat = pk_re2[W] || pk_im2[W];
        if (is_sqrt)
            s2_side_next = {s1_ar_reg, {W{1'b0}}};
        else
            s2_side_next = {pk_re2[W-1:0], pk_im2[W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_ctl_reg <= '0;
        else if (adv)
            s2_ctl_reg <= s2_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s2_side_next;
            s2_p0_reg   <= s1_ar_reg * m0b;
            s2_p1_reg   <= s1_ai_reg * m1b;
            s2_p2_reg   <= s1_ai_reg * s1_br_reg;
            s2_p3_reg   <= s1_ar_reg * s1_bi_reg;
            s2_q0_reg   <= s1_br_reg * s1_br_reg;
            s2_q1_reg   <= s1_bi_reg * s1_bi_reg;
        end
    end

    // stage 3
    always_comb
    begin
        case (s2_ctl_reg.op)
            cau_pkg::OP_MUL:
            begin
                s3_sr_next = SW'(s2_p0_reg) - SW'(s2_p1_reg);
                s3_si_next = SW'(s2_p2_reg) + SW'(s2_p3_reg);
            end
            cau_pkg::OP_DIV:
            begin
                s3_sr_next = SW'(s2_p0_reg) + SW'(s2_p1_reg);
                s3_si_next = SW'(s2_p2_reg) - SW'(s2_p3_reg);
            end
            default:
            begin
                s3_sr_next = SW'(s2_p0_reg) + SW'(s2_p1_reg);
                s3_si_next = SW'(s2_p2_reg) + SW'(s2_p3_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_ctl_reg <= '0;
        else if (adv)
            s3_ctl_reg <= s2_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= s2_side_reg;
            s3_sr_reg   <= s3_sr_next;
            s3_si_reg   <= s3_si_next;
            s3_d_reg    <= PW'(s2_q0_reg) + PW'(s2_q1_reg);
        end
    end

    // stage 4
    always_comb
    begin
        shr_re       = s3_sr_reg >>> F;
        shr_im       = s3_si_reg >>> F;
        pk_re4       = sat_sgn(shr_re);
        pk_im4       = sat_sgn(shr_im);
        abs_re       = s3_sr_reg[SW-1] ? SW'(-s3_sr_reg) : SW'(s3_sr_reg);
        abs_im       = s3_si_reg[SW-1] ? SW'(-s3_si_reg) : SW'(s3_si_reg);
        s4_ctl_next  = s3_ctl_reg;
        s4_side_next = s3_side_reg;
        case (s3_ctl_reg.op)
            cau_pkg::OP_MUL:
            begin
                s4_side_next    = {pk_re4[W-1:0], pk_im4[W-1:0]};
                s4_ctl_next.sat = pk_re4[W] || pk_im4[W];
            end
            cau_pkg::OP_DIV:
            begin
                s4_ctl_next.neg_re = s3_sr_reg[SW-1];
                s4_ctl_next.neg_im = s3_si_reg[SW-1];
                s4_ctl_next.dz     = s3_d_reg == '0;
            end
            default:
            begin
                s4_ctl_next.neg_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_ctl_reg <= '0;
        else if (adv)
            s4_ctl_reg <= s4_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= s4_side_next;
            s4_mr_reg   <= abs_re[PW-1:0];
            s4_mi_reg   <= abs_im[PW-1:0];
            s4_d_reg    <= s3_d_reg;
        end
    end

    // stage 5: top part of the shifted dividend is the first partial remainder
    always_comb
    begin
        x_re    = XW'(s4_mr_reg) << F;
        x_im    = XW'(s4_mi_reg) << F;
        r0_re   = CW'(x_re[XW-1:W]);
        r0_im   = CW'(x_im[XW-1:W]);
        d_ext   = CW'(s4_d_reg);
        ovf_re5 = r0_re >= d_ext;
        ovf_im5 = r0_im >= d_ext;
        s5_ctl_next        = s4_ctl_reg;
        s5_ctl_next.ovf_re = ovf_re5;
        s5_ctl_next.ovf_im = ovf_im5;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ch1_ctl_reg[0] <= '0;
        else if (adv)
            ch1_ctl_reg[0] <= s5_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ch1_side_reg[0] <= s4_side_reg;
            s5_rem_re_reg   <= ovf_re5 ? '0 : r0_re[PW-1:0];
            s5_rem_im_reg   <= ovf_im5 ? '0 : r0_im[PW-1:0];
            s5_xl_re_reg    <= x_re[W-1:0];
            s5_xl_im_reg    <= x_im[W-1:0];
            s5_d_reg        <= s4_d_reg;
            s5_xs_reg       <= s4_mr_reg;
        end
    end

    assign dv_d[0]      = s5_d_reg;
    assign dv_rem_re[0] = s5_rem_re_reg;
    assign dv_rem_im[0] = s5_rem_im_reg;
    assign dv_xl_re[0]  = s5_xl_re_reg;
    assign dv_xl_im[0]  = s5_xl_im_reg;
    assign dv_q_re[0]   = '0;
    assign dv_q_im[0]   = '0;
    assign sq_rem[0]    = '0;
    assign sq_root[0]   = '0;
    assign sq_xs[0]     = s5_xs_reg;

    for (genvar k = 0; k < W; k++)
    begin : g_row1
        cau_div_cell #(
            .WORD_BITS (W)
        ) u_div (
            .clk        (clk),
            .en         (adv),
            .d_in       (dv_d[k]),
            .rem_re_in  (dv_rem_re[k]),
            .rem_im_in  (dv_rem_im[k]),
            .xl_re_in   (dv_xl_re[k]),
            .xl_im_in   (dv_xl_im[k]),
            .q_re_in    (dv_q_re[k]),
            .q_im_in    (dv_q_im[k]),
            .d_out      (dv_d[k+1]),
            .rem_re_out (dv_rem_re[k+1]),
            .rem_im_out (dv_rem_im[k+1]),
            .xl_re_out  (dv_xl_re[k+1]),
            .xl_im_out  (dv_xl_im[k+1]),
            .q_re_out   (dv_q_re[k+1]),
            .q_im_out   (dv_q_im[k+1])
        );

        cau_sqrt_cell #(
            .ROOT_BITS (W)
        ) u_mod (
            .clk      (clk),
            .en       (adv),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .xs_in    (sq_xs[k]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .xs_out   (sq_xs[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ch1_ctl_reg[k+1] <= '0;
            else if (adv)
                ch1_ctl_reg[k+1] <= ch1_ctl_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                ch1_side_reg[k+1] <= ch1_side_reg[k];
        end
    end

    // between rows: finish the quotients, form the half sums for the roots
    always_comb
    begin
        t_ar    = ch1_side_reg[W][2*W-1:W];
        v_p     = {1'b0, sq_root[W]} + {t_ar[W-1], t_ar};
        v_m     = {1'b0, sq_root[W]} - {t_ar[W-1], t_ar};
        tw_p    = (TW'(v_p) << F) >> 1;
        tw_m    = (TW'(v_m) << F) >> 1;
        pk_re_t = pack_mag(ch1_ctl_reg[W].neg_re, ch1_ctl_reg[W].ovf_re,
                           MX'(dv_q_re[W]));
        pk_im_t = pack_mag(ch1_ctl_reg[W].neg_im, ch1_ctl_reg[W].ovf_im,
                           MX'(dv_q_im[W]));
        t_ctl_next  = ch1_ctl_reg[W];
        t_side_next = ch1_side_reg[W];
        if (ch1_ctl_reg[W].op == cau_pkg::OP_DIV)
        begin
            if (ch1_ctl_reg[W].dz)
            begin
                t_side_next = '0;
            end
            else
            begin
                t_side_next    = {pk_re_t[W-1:0], pk_im_t[W-1:0]};
                t_ctl_next.sat = pk_re_t[W] || pk_im_t[W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ch2_ctl_reg[0] <= '0;
        else if (adv)
            ch2_ctl_reg[0] <= t_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ch2_side_reg[0] <= t_side_next;
            t_xs_re_reg     <= X2W'(tw_p);
            t_xs_im_reg     <= X2W'(tw_m);
        end
    end

    assign rr_rem[0]  = '0;
    assign rr_root[0] = '0;
    assign rr_xs[0]   = t_xs_re_reg;
    assign ri_rem[0]  = '0;
    assign ri_root[0] = '0;
    assign ri_xs[0]   = t_xs_im_reg;

    for (genvar k = 0; k < NB2; k++)
    begin : g_row2
        cau_sqrt_cell #(
            .ROOT_BITS (NB2)
        ) u_re (
            .clk      (clk),
            .en       (adv),
            .rem_in   (rr_rem[k]),
            .root_in  (rr_root[k]),
            .xs_in    (rr_xs[k]),
            .rem_out  (rr_rem[k+1]),
            .root_out (rr_root[k+1]),
            .xs_out   (rr_xs[k+1])
        );

        cau_sqrt_cell #(
            .ROOT_BITS (NB2)
        ) u_im (
            .clk      (clk),
            .en       (adv),
            .rem_in   (ri_rem[k]),
            .root_in  (ri_root[k]),
            .xs_in    (ri_xs[k]),
            .rem_out  (ri_rem[k+1]),
            .root_out (ri_root[k+1]),
            .xs_out   (ri_xs[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ch2_ctl_reg[k+1] <= '0;
            else if (adv)
                ch2_ctl_reg[k+1] <= ch2_ctl_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                ch2_side_reg[k+1] <= ch2_side_reg[k];
        end
    end

    // output register
    always_comb
    begin
        oc      = ch2_ctl_reg[NB2];
        pk_re_o = pack_mag(1'b0, 1'b0, MX'(rr_root[NB2]));
        pk_im_o = pack_mag(oc.neg_im, 1'b0, MX'(ri_root[NB2]));
        if (oc.op == cau_pkg::OP_SQRT)
        begin
            o_re_next = pk_re_o[W-1:0];
            o_im_next = pk_im_o[W-1:0];
            o_sat     = pk_re_o[W] || pk_im_o[W];
        end
        else
        begin
            o_re_next = ch2_side_reg[NB2][2*W-1:W];
            o_im_next = ch2_side_reg[NB2][W-1:0];
            o_sat     = oc.sat;
        end
        if (oc.dz)
            o_st_next = cau_pkg::ST_DZ;
        else if (o_sat)
            o_st_next = cau_pkg::ST_SAT;
        else
            o_st_next = cau_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= oc.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_re_reg <= IO'(o_re_next);
            res_im_reg <= IO'(o_im_next);
            status_reg <= o_st_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign status    = status_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cau_pkg::ST_DZ |-> res_re == '0 && res_im == '0)
        else $error("divide by zero beat with nonzero result");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cau_pkg::ST_SAT |->
            res_re == SAT_POS || res_re == SAT_NEG ||
            res_im == SAT_POS || res_im == SAT_NEG)
        else $error("saturated beat with no part at a limit");

endmodule

// File: sim/complex_arithmetic_unit_test.sv
// self-checking bench for complex_arithmetic_unit: directed and random operand beats,
// predicted results kept in order and compared field by field; depends on cau_pkg
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;

    localparam int FRAC = cau_pkg::FRAC_BITS_DEF;
    localparam int IOW  = cau_pkg::IO_BITS;
    localparam int OPW  = cau_pkg::OP_BITS;
    localparam int STW  = cau_pkg::ST_BITS;

    typedef struct {
        logic signed [IOW-1:0] re;
        logic signed [IOW-1:0] im;
        logic [STW-1:0]        st;
    } cplx_result_t;

    class complex_result_tracker;
        cplx_result_t pending_results[$];
        int           mismatches = 0;
        bit           clamped;

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > x)
                b >>= 2;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function logic signed [IOW-1:0] clamp_word(logic signed [127:0] v);
            if (v > 128'sh7fffffff)
            begin
                clamped = 1;
                return 32'sh7fffffff;
            end
            if (v < -128'sh80000000)
            begin
                clamped = 1;
                return 32'sh80000000;
            end
            return v[IOW-1:0];
        endfunction

        function void note_operands(logic [OPW-1:0] opc, logic signed [IOW-1:0] xr,
                                    logic signed [IOW-1:0] xi,
                                    logic signed [IOW-1:0] yr,
                                    logic signed [IOW-1:0] yi);
            logic signed [127:0] ar, ai, br, bi, vr, vi, d;
            longint unsigned m;
            cplx_result_t r;
            ar = xr;
            ai = xi;
            br = yr;
            bi = yi;
            vr = 0;
            vi = 0;
            clamped = 0;
            r.st = cau_pkg::ST_OK;
            case (opc)
                cau_pkg::OP_COPY:
                begin
                    vr = ar;
                    vi = ai;
                end
                cau_pkg::OP_ADD:
                begin
                    vr = ar + br;
                    vi = ai + bi;
                end
                cau_pkg::OP_SUB:
                begin
                    vr = ar - br;
                    vi = ai - bi;
                end
                cau_pkg::OP_MUL:
                begin
                    vr = (ar * br - ai * bi) >>> FRAC;
                    vi = (ai * br + ar * bi) >>> FRAC;
                end
                cau_pkg::OP_DIV:
                begin
                    d = br * br + bi * bi;
                    if (d == 0)
                        r.st = cau_pkg::ST_DZ;
                    else
                    begin
                        vr = ((ar * br + ai * bi) <<< FRAC) / d;
                        vi = ((ai * br - ar * bi) <<< FRAC) / d;
                    end
                end
                cau_pkg::OP_SQRT:
                begin
                    d = ar * ar + ai * ai;
                    m = int_sqrt(d[63:0]);
                    vr = int_sqrt(((m + ar[63:0]) << FRAC) >> 1);
                    vi = int_sqrt(((m - ar[63:0]) << FRAC) >> 1);
                    if (ai < 0)
                        vi = -vi;
                end
                default:
                begin
                end
            endcase
            r.re = clamp_word(vr);
            r.im = clamp_word(vi);
            if (r.st == cau_pkg::ST_OK && clamped)
                r.st = cau_pkg::ST_SAT;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic signed [IOW-1:0] gr, logic signed [IOW-1:0] gi,
                                   logic [STW-1:0] gs);
            cplx_result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result re %h im %h status %0d", $time, gr, gi, gs);
                mismatches++;
                return;
            end
            e = pending_results.pop_front();
            if (gr !== e.re)
            begin
                $display("%0t: res_re expected %h actual %h", $time, e.re, gr);
                mismatches++;
            end
            if (gi !== e.im)
            begin
                $display("%0t: res_im expected %h actual %h", $time, e.im, gi);
                mismatches++;
            end
            if (gs !== e.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, gs);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_stall;
    logic [OPW-1:0]        op = '0;
    logic signed [IOW-1:0] a_re = '0;
    logic signed [IOW-1:0] a_im = '0;
    logic signed [IOW-1:0] b_re = '0;
    logic signed [IOW-1:0] b_im = '0;
    logic                  out_valid;
    logic                  out_stall = 0;
    logic signed [IOW-1:0] res_re;
    logic signed [IOW-1:0] res_im;
    logic [STW-1:0]        status;

    complex_result_tracker tracker = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    complex_arithmetic_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_re(res_re), .res_im(res_im), .status(status)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(res_re, res_im, status);

    task automatic send_beat(logic [OPW-1:0] opc, logic signed [IOW-1:0] xr,
                             logic signed [IOW-1:0] xi, logic signed [IOW-1:0] yr,
                             logic signed [IOW-1:0] yi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        op <= opc;
        a_re <= xr;
        a_im <= xi;
        b_re <= yr;
        b_im <= yi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_operands(opc, xr, xi, yr, yi);
    endtask

    function automatic logic signed [IOW-1:0] pick_part();
        logic signed [IOW-1:0] corner[6] = '{32'sh80000000, 32'sh7fffffff, 0, 1, -1,
                                             32'sh00010000};
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(1 << 20)) - (1 << 19);
            2: return corner[$urandom_range(5)];
            default: return $signed($urandom_range(1 << 25)) - (1 << 24);
        endcase
    endfunction

    task automatic send_random_beat();
        logic [OPW-1:0] opc;
        logic signed [IOW-1:0] yr, yi;
        opc = ($urandom_range(19) == 0) ? OPW'($urandom_range(7, 6))
                                        : OPW'($urandom_range(5));
        yr = pick_part();
        yi = pick_part();
        if (opc == cau_pkg::OP_DIV && $urandom_range(15) == 0)
        begin
            yr = 0;
            yi = 0;
        end
        send_beat(opc, pick_part(), pick_part(), yr, yi);
    endtask

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int idle_plan[4] = '{0, 79, 0, 24};
        int stall_plan[4] = '{0, 0, 79, 24};
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_beat(cau_pkg::OP_COPY, 32'sh7fffffff, 32'sh80000000, 0, 0);
        send_beat(cau_pkg::OP_ADD, 32'sh7fffffff, 32'sh80000000, 1, -1);
        send_beat(cau_pkg::OP_ADD, 32'sh00010000, -32'sh00020000, 32'sh00030000, 5);
        send_beat(cau_pkg::OP_SUB, 32'sh80000000, 32'sh7fffffff, 1, -1);
        send_beat(cau_pkg::OP_SUB, 32'sh80000000, 0, 32'sh80000000, 0);
        send_beat(cau_pkg::OP_MUL, 32'sh00020000, 32'sh00030000, -32'sh00010000,
                  32'sh00008000);
        send_beat(cau_pkg::OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000);
        send_beat(cau_pkg::OP_MUL, -1, 0, 1, 0);
        send_beat(cau_pkg::OP_DIV, 32'sh00010000, 0, 0, 0);
        send_beat(cau_pkg::OP_DIV, 32'sh00050000, -32'sh00030000, 32'sh00020000,
                  32'sh00010000);
        send_beat(cau_pkg::OP_DIV, 32'sh7fffffff, 32'sh80000000, 1, 0);
        send_beat(cau_pkg::OP_DIV, -3, 7, 32'sh00030000, 0);
        send_beat(cau_pkg::OP_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000);
        send_beat(cau_pkg::OP_SQRT, 32'sh00040000, 0, 0, 0);
        send_beat(cau_pkg::OP_SQRT, -32'sh00040000, 0, 0, 0);
        send_beat(cau_pkg::OP_SQRT, -32'sh00040000, -1, 0, 0);
        send_beat(cau_pkg::OP_SQRT, 32'sh80000000, 32'sh80000000, 0, 0);
        send_beat(cau_pkg::OP_SQRT, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
        send_beat(cau_pkg::OP_SQRT, 0, 0, 0, 0);
        send_beat(OPW'(6), 5, 6, 7, 8);
        send_beat(OPW'(7), -1, -1, -1, -1);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            repeat (345)
                send_random_beat();
        end
        in_valid <= 0;

        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
